### sv/url_split_stream_parser_core_assert.svh
// ----------------------------------------------------------------------------
// URL splitter assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef URL_SPLIT_STREAM_PARSER_CORE_ASSERT_SVH
`define URL_SPLIT_STREAM_PARSER_CORE_ASSERT_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset
`define USP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds outside reset
`define USP_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define USP_ASSERT(label, clk, rst, prop, msg)
`define USP_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

### sv/usp_pkg.sv
// ----------------------------------------------------------------------------
// URL splitter package
// Shared constants, result kinds, the classified word and the prefix table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package usp_pkg;

   localparam int unsigned MAX_HELD_SPACES_DEF = 16;
   localparam int unsigned QUEUE_DEPTH_DEF     = 2;
   localparam logic [15:0] DEFAULT_PORT_RST    = 16'd80;
   localparam int unsigned PFX_LEN             = 4;

   // Result word layout
   localparam int unsigned RSP_FIELDS_W = 27;
   localparam int unsigned RSP_DATA_W   = 32;
   localparam int unsigned RSP_USER_W   = 2;

   // Character codes
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_LOW_S  = 8'h73;
   localparam logic [7:0] CASE_BIT  = 8'h20;

   typedef enum logic [1:0] {
      KIND_HOST    = 2'd0,
      KIND_URI     = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   // One input byte with its class flags
   typedef struct packed {
      logic [7:0] byte_val;
      logic [7:0] lower;
      logic       fin;
      logic       is_ws;
      logic       is_colon;
      logic       is_slash;
      logic       is_digit;
   } usp_class_type;

   // Lower-case scheme text, one character per prefix position
   function automatic logic [7:0] pfx_char(input logic [1:0] idx);
      logic [7:0] c;
      unique case (idx)
         2'd0: c = 8'h68;
         2'd1: c = 8'h74;
         2'd2: c = 8'h74;
         2'd3: c = 8'h70;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

### sv/url_split_stream_parser_core.sv
// ----------------------------------------------------------------------------
// URL split stream parser
// Splits a byte stream of URL text into host bytes, uri bytes and a
// per-URL summary of scheme and port. A byte that breaks a partial scheme
// match is taken first, then the held scheme bytes are replayed as host
// text and then the byte itself is carried out. A byte that releases held
// whitespace bytes ahead of itself first reads them out of the whitespace
// store, which has a registered read. A last byte that ends the URL inside
// a partial scheme match releases its held scheme bytes as host text. Each
// URL ends with a summary word. The sequencer drives at most one result
// word per cycle, while the result side keeps up, through a single output
// register. A short input queue lets the input side keep flowing while the
// sequencer is busy. The default port register must only be written while
// no URL is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "url_split_stream_parser_core_assert.svh"

module url_split_stream_parser_core #(
   parameter int unsigned MAX_HELD_SPACES = usp_pkg::MAX_HELD_SPACES_DEF,
   parameter int unsigned QUEUE_DEPTH     = usp_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,  // [7:0] char_byte
   input  wire logic                              req_tlast,  // final_byte
   // result channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [7:0] text_byte, [8] is_https, [24:9] port_number, [25] port_saturated,
   // [26] space_overflow, [31:27] zero
   output logic [usp_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [usp_pkg::RSP_USER_W-1:0]         rsp_tuser,  // [1:0] item_kind
   output logic                                   rsp_tlast,  // run_last
   // configuration
   input  wire logic                              csr_wen,
   input  wire logic [15:0]                       csr_wdata   // default_port
);

   import usp_pkg::*;

   logic [15:0]   default_port_ff;
   logic          q_push, q_full, q_pop, q_valid;
   usp_class_type q_wdata, q_head;

   // Default port register
   always_ff @(posedge clock) begin
      if (reset) begin
         default_port_ff <= DEFAULT_PORT_RST;
      end else if (csr_wen) begin
         default_port_ff <= csr_wdata;
      end
   end

   // Accept and classify
   usp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   // Decouple front end and sequencer
   usp_queue #(
      .WIDTH ($bits(usp_class_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_head),
      .valid (q_valid)
   );

   // Parse and emit
   usp_back #(
      .MAX_HELD_SPACES (MAX_HELD_SPACES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .head_valid   (q_valid),
      .head_pop     (q_pop),
      .default_port (default_port_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

   // Checks
   `USP_ASSERT(a_sum_last, clock, reset, rsp_tvalid && (rsp_tuser == KIND_SUMMARY) |-> rsp_tlast, "summary word without tlast")
   `USP_ASSERT(a_byte_clean, clock, reset, rsp_tvalid && (rsp_tuser != KIND_SUMMARY) |-> (rsp_tdata[26:8] == 19'd0), "byte word carries summary fields")
   `USP_ASSERT_NEVER(a_pop_empty, clock, reset, q_pop && !q_valid, "sequencer popped an empty queue")

endmodule

`default_nettype wire

### sv/usp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and read into a registered output; hold data when not reading
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/usp_queue.sv
// ----------------------------------------------------------------------------
// URL splitter word queue
// Short FIFO between the classifying front end and the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usp_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  valid
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

   assign full  = (count_ff == CW'(DEPTH));
   assign valid = (count_ff != '0);
   assign rdata = mem_ff[rptr_ff];

endmodule

`default_nettype wire

### sv/usp_front.sv
// ----------------------------------------------------------------------------
// URL splitter front end
// Accepts input words and tags each byte with its character class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usp_front (
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,   // char_byte
   input  wire logic                 req_tlast,   // final_byte
   input  wire logic                 q_full,
   output logic                      q_push,
   output usp_pkg::usp_class_type    q_wdata
);

   import usp_pkg::*;

   logic [7:0] b;

   assign b = req_tdata;

   // Take a word whenever the queue has room
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // Classify the byte
   always_comb begin
      q_wdata.byte_val = b;
      q_wdata.lower    = (b >= CH_UP_A && b <= CH_UP_Z) ? (b | CASE_BIT) : b;
      q_wdata.fin      = req_tlast;
      q_wdata.is_ws    = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
      q_wdata.is_colon = (b == CH_COLON);
      q_wdata.is_slash = (b == CH_SLASH) || (b == CH_BSLASH);
      q_wdata.is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
   end

endmodule

`default_nettype wire

### sv/usp_back.sv
// ----------------------------------------------------------------------------
// URL splitter sequencer
// Runs the parse state per byte and emits host, uri and summary words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usp_back #(
   parameter int unsigned MAX_HELD_SPACES = usp_pkg::MAX_HELD_SPACES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire usp_pkg::usp_class_type            head,
   input  wire logic                              head_valid,
   output logic                                   head_pop,
   input  wire logic [15:0]                       default_port,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [usp_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [usp_pkg::RSP_USER_W-1:0]         rsp_tuser,
   output logic                                   rsp_tlast
);

   import usp_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_HELD_SPACES + 1);
   localparam int unsigned AW    = (MAX_HELD_SPACES > 1) ? $clog2(MAX_HELD_SPACES) : 1;
   localparam int unsigned PAD_W = RSP_DATA_W - RSP_FIELDS_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_REPLAY, ST_BODY, ST_FLUSH, ST_BYTE, ST_SUM
   } state_type;

   typedef enum logic [2:0] {
      PH_LEAD, PH_PREFIX, PH_SEP, PH_HOST, PH_PORT, PH_URI
   } phase_type;

   typedef struct packed {
      phase_type ph_n;
      logic      emit;
      logic      flush;
      kind_type  kind;
      logic      host_set;
      logic      pend_clr;
      logic      hold;
      logic      digit;
   } body_type;

   // Control state
   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [2:0]    pmatch_ff, pmatch_in;
   logic          https_ff, https_in;
   logic [15:0]   port_ff, port_in;
   logic          digits_ff, digits_in;
   logic          over_ff, over_in;
   logic          hbegun_ff, hbegun_in;
   logic [CNT_W-1:0] pcnt_ff, pcnt_in;
   logic          lost_ff, lost_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Working registers
   usp_class_type cur_ff, cur_in;
   logic [7:0]    held_ff [PFX_LEN];
   logic [7:0]    held_in [PFX_LEN];
   logic [2:0]    rp_cnt_ff, rp_cnt_in;
   logic [1:0]    rp_idx_ff, rp_idx_in;
   logic          cont_ff, cont_in;
   logic [AW-1:0] fl_idx_ff, fl_idx_in;
   kind_type      bkind_ff, bkind_in;

   // Output register
   kind_type      o_kind_ff, o_kind_in;
   logic [7:0]    o_byte_ff, o_byte_in;
   logic          o_https_ff, o_https_in;
   logic [15:0]   o_port_ff, o_port_in;
   logic          o_sat_ff, o_sat_in;
   logic          o_ovf_ff, o_ovf_in;
   logic          o_last_ff, o_last_in;

   // Datapath
   usp_class_type bsel;
   phase_type     bph, bph_e;
   logic          bsep;
   body_type      bd;
   logic [19:0]   port_mul;
   logic          port_big;
   logic [2:0]    k, k_nxt;
   logic          k_full, in_pfx, lead_skip, pfx_hit;
   logic          out_free, commit_body, rp_last;
   logic [CNT_W-1:0] fl_nxt;
   logic          emit, e_https, e_sat, e_ovf, e_last;
   kind_type      e_kind;
   logic [7:0]    e_byte;
   logic [15:0]   e_port;
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   // Held whitespace store
   usp_ram #(
      .WIDTH (8),
      .DEPTH (MAX_HELD_SPACES)
   ) u_spaces (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pcnt_ff[AW-1:0]),
      .wr_data (bsel.byte_val),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Pick the byte under work: queue head when idle, else the saved word
   always_comb begin
      bsel = (state_ff == ST_IDLE) ? head : cur_ff;
      bph  = phase_ff;
      if (state_ff == ST_IDLE && (phase_ff == PH_LEAD || phase_ff == PH_PREFIX)) begin
         bph = PH_SEP;
      end
      bsep  = bsel.is_colon || bsel.is_slash;
      bph_e = (bph == PH_SEP && !bsep) ? PH_HOST : bph;
   end

   // Decode what a host, port or uri byte does
   always_comb begin
      bd.ph_n     = bph_e;
      bd.emit     = 1'b0;
      bd.flush    = 1'b0;
      bd.kind     = KIND_URI;
      bd.host_set = 1'b0;
      bd.pend_clr = 1'b0;
      bd.hold     = 1'b0;
      bd.digit    = 1'b0;
      unique case (bph_e)
         PH_HOST: begin
            if (bsel.is_colon) begin
               bd.pend_clr = 1'b1;
               bd.ph_n     = PH_PORT;
            end else if (bsel.is_slash) begin
               bd.pend_clr = 1'b1;
               bd.ph_n     = PH_URI;
               bd.emit     = 1'b1;
            end else if (bsel.is_ws) begin
               bd.hold = hbegun_ff;
            end else begin
               bd.flush    = (pcnt_ff != '0);
               bd.host_set = 1'b1;
               bd.emit     = 1'b1;
               bd.kind     = KIND_HOST;
            end
         end
         PH_PORT: begin
            if (bsep) begin
               bd.ph_n = PH_URI;
               bd.emit = 1'b1;
            end else if (bsel.is_digit) begin
               bd.digit = 1'b1;
            end
         end
         PH_URI: begin
            if (bsel.is_ws) begin
               bd.hold = 1'b1;
            end else begin
               bd.flush = (pcnt_ff != '0);
               bd.emit  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Port accumulate: value * 10 + digit, saturating
   assign port_mul = ({4'd0, port_ff} << 3) + ({4'd0, port_ff} << 1)
                   + {16'd0, bsel.byte_val[3:0]};
   assign port_big = over_ff || (port_mul[19:16] != 4'd0);

   // Prefix match on the queue head
   assign k         = (phase_ff == PH_PREFIX) ? pmatch_ff : 3'd0;
   assign k_nxt     = k + 3'd1;
   assign k_full    = (k == 3'(PFX_LEN));
   assign in_pfx    = (phase_ff == PH_PREFIX) || (phase_ff == PH_LEAD && !head.is_ws);
   assign lead_skip = (phase_ff == PH_LEAD) && head.is_ws;
   assign pfx_hit   = !k_full && (head.lower == pfx_char(k[1:0]));
   assign rp_last   = (({1'b0, rp_idx_ff} + 3'd1) == rp_cnt_ff);
   assign fl_nxt    = CNT_W'(fl_idx_ff) + CNT_W'(1);

   // Sequencer: one result word per cycle at most
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      pmatch_in = pmatch_ff;
      https_in  = https_ff;
      port_in   = port_ff;
      digits_in = digits_ff;
      over_in   = over_ff;
      hbegun_in = hbegun_ff;
      pcnt_in   = pcnt_ff;
      lost_in   = lost_ff;
      cur_in    = cur_ff;
      held_in   = held_ff;
      rp_cnt_in = rp_cnt_ff;
      rp_idx_in = rp_idx_ff;
      cont_in   = cont_ff;
      fl_idx_in = fl_idx_ff;
      bkind_in  = bkind_ff;

      head_pop    = 1'b0;
      commit_body = 1'b0;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_raddr   = '0;

      emit    = 1'b0;
      e_kind  = KIND_HOST;
      e_byte  = 8'd0;
      e_https = 1'b0;
      e_port  = 16'd0;
      e_sat   = 1'b0;
      e_ovf   = 1'b0;
      e_last  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid && out_free) begin
               head_pop = 1'b1;
               cur_in   = head;
               if (lead_skip) begin
                  state_in = head.fin ? ST_SUM : ST_IDLE;
               end else if (in_pfx && pfx_hit) begin
                  // store a matching scheme byte
                  held_in[k[1:0]] = head.byte_val;
                  pmatch_in       = k_nxt;
                  phase_in        = PH_PREFIX;
                  if (head.fin) begin
                     if (k_nxt != 3'(PFX_LEN)) begin
                        rp_cnt_in = k_nxt;
                        rp_idx_in = 2'd0;
                        cont_in   = 1'b0;
                        state_in  = ST_REPLAY;
                     end else begin
                        state_in = ST_SUM;
                     end
                  end
               end else if (in_pfx && !k_full && k != 3'd0) begin
                  // mismatch: replay held bytes as host, then this byte
                  phase_in  = PH_HOST;
                  hbegun_in = 1'b1;
                  pmatch_in = 3'd0;
                  rp_cnt_in = k;
                  rp_idx_in = 2'd0;
                  cont_in   = 1'b1;
                  state_in  = ST_REPLAY;
               end else if (in_pfx && k_full && head.lower == CH_LOW_S) begin
                  https_in  = 1'b1;
                  phase_in  = PH_SEP;
                  pmatch_in = 3'd0;
                  state_in  = head.fin ? ST_SUM : ST_IDLE;
               end else begin
                  pmatch_in   = 3'd0;
                  commit_body = 1'b1;
               end
            end
         end
         ST_REPLAY: begin
            if (out_free) begin
               emit      = 1'b1;
               e_kind    = KIND_HOST;
               e_byte    = held_ff[rp_idx_ff];
               e_last    = rp_last && !cur_ff.fin && !(cont_ff && (bd.emit || bd.flush));
               rp_idx_in = rp_idx_ff + 2'd1;
               if (rp_last) begin
                  state_in = cont_ff ? ST_BODY : ST_SUM;
               end
            end
         end
         ST_BODY: begin
            if (out_free) begin
               commit_body = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               emit   = 1'b1;
               e_kind = bkind_ff;
               e_byte = ram_rdata;
               if (fl_nxt < pcnt_ff) begin
                  ram_re    = 1'b1;
                  ram_raddr = fl_nxt[AW-1:0];
                  fl_idx_in = fl_nxt[AW-1:0];
               end else begin
                  pcnt_in  = '0;
                  state_in = ST_BYTE;
               end
            end
         end
         ST_BYTE: begin
            if (out_free) begin
               emit     = 1'b1;
               e_kind   = bkind_ff;
               e_byte   = cur_ff.byte_val;
               e_last   = !cur_ff.fin;
               state_in = cur_ff.fin ? ST_SUM : ST_IDLE;
            end
         end
         ST_SUM: begin
            if (out_free) begin
               emit    = 1'b1;
               e_kind  = KIND_SUMMARY;
               e_https = https_ff;
               e_port  = digits_ff ? port_ff : default_port;
               e_sat   = over_ff;
               e_ovf   = lost_ff;
               e_last  = 1'b1;
               // drop all per-URL state
               phase_in  = PH_LEAD;
               pmatch_in = 3'd0;
               https_in  = 1'b0;
               port_in   = 16'd0;
               digits_in = 1'b0;
               over_in   = 1'b0;
               hbegun_in = 1'b0;
               pcnt_in   = '0;
               lost_in   = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Carry out a host, port or uri byte
      if (commit_body) begin
         phase_in = bd.ph_n;
         if (bd.host_set) begin
            hbegun_in = 1'b1;
         end
         if (bd.pend_clr) begin
            pcnt_in = '0;
         end
         if (bd.hold) begin
            if (pcnt_ff < CNT_W'(MAX_HELD_SPACES)) begin
               ram_we  = 1'b1;
               pcnt_in = pcnt_ff + CNT_W'(1);
            end else begin
               lost_in = 1'b1;
            end
         end
         if (bd.digit) begin
            digits_in = 1'b1;
            if (port_big) begin
               port_in = 16'hFFFF;
               over_in = 1'b1;
            end else begin
               port_in = port_mul[15:0];
            end
         end
         if (bd.flush) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            fl_idx_in = '0;
            bkind_in  = bd.kind;
            state_in  = ST_FLUSH;
         end else begin
            if (bd.emit) begin
               emit   = 1'b1;
               e_kind = bd.kind;
               e_byte = bsel.byte_val;
               e_last = !bsel.fin;
            end
            state_in = bsel.fin ? ST_SUM : ST_IDLE;
         end
      end
   end

   // Load the output register on a new word, drop it once taken
   always_comb begin
      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      o_kind_in    = emit ? e_kind  : o_kind_ff;
      o_byte_in    = emit ? e_byte  : o_byte_ff;
      o_https_in   = emit ? e_https : o_https_ff;
      o_port_in    = emit ? e_port  : o_port_ff;
      o_sat_in     = emit ? e_sat   : o_sat_ff;
      o_ovf_in     = emit ? e_ovf   : o_ovf_ff;
      o_last_in    = emit ? e_last  : o_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LEAD;
         pmatch_ff    <= 3'd0;
         https_ff     <= 1'b0;
         port_ff      <= 16'd0;
         digits_ff    <= 1'b0;
         over_ff      <= 1'b0;
         hbegun_ff    <= 1'b0;
         pcnt_ff      <= '0;
         lost_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pmatch_ff    <= pmatch_in;
         https_ff     <= https_in;
         port_ff      <= port_in;
         digits_ff    <= digits_in;
         over_ff      <= over_in;
         hbegun_ff    <= hbegun_in;
         pcnt_ff      <= pcnt_in;
         lost_ff      <= lost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff     <= cur_in;
      held_ff    <= held_in;
      rp_cnt_ff  <= rp_cnt_in;
      rp_idx_ff  <= rp_idx_in;
      cont_ff    <= cont_in;
      fl_idx_ff  <= fl_idx_in;
      bkind_ff   <= bkind_in;
      o_kind_ff  <= o_kind_in;
      o_byte_ff  <= o_byte_in;
      o_https_ff <= o_https_in;
      o_port_ff  <= o_port_in;
      o_sat_ff   <= o_sat_in;
      o_ovf_ff   <= o_ovf_in;
      o_last_ff  <= o_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, o_ovf_ff, o_sat_ff, o_port_ff, o_https_ff, o_byte_ff};
   assign rsp_tuser  = o_kind_ff;
   assign rsp_tlast  = o_last_ff;

endmodule

`default_nettype wire
